// ----- sv/lcs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the LCS table and traceback block: field widths,
// request codes and direction marks. No dependencies.
package lcs_pkg;

	// Default string length
	localparam int MAX_LEN_DEF = 64;

	// Fixed field widths
	localparam int SYM_W = 8;
	localparam int LEN_W = 7;
	localparam int REQ_W = 2;
	localparam int DIR_W = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_APPEND_A = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND_B = 2'd1;
	localparam logic [REQ_W-1:0] REQ_COMPUTE  = 2'd2;

	// Direction marks kept per table cell
	localparam logic [DIR_W-1:0] DIR_DIAG = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT = 2'd2;

endpackage

// ----- sv/lcs_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module lcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write, and register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/lcs_dp_traceback.sv -----
`timescale 1ns / 1ps
// Longest common subsequence block: string stores, table fill, traceback and
// result emission under one sequencer. Uses lcs_pkg and lcs_ram.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  request | req_valid, req_stall, req_type, symbol         | in
//  result  | res_valid, res_stall, lcs_symbol, lcs_length,  | out
//          | is_empty, overflowed, last                     |
//
// An append transaction is taken while idle. A compute transaction walks the table
// through one shared compare/add unit: each row passes S_ROW and S_ROWW and each
// cell S_CELL and S_CALC, then each traceback step passes S_TB and S_TBW, then each
// result S_EADDR and S_ELOAD. The request side is stalled for all of that.
// Reset clears counts, drop flag and sequencer; the stores need no clearing.
// A stalled result is held in the output register while the sequencer waits.
module lcs_dp_traceback #(
	parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [lcs_pkg::REQ_W-1:0]   req_type,
	input  logic [lcs_pkg::SYM_W-1:0]   symbol,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [lcs_pkg::SYM_W-1:0]   lcs_symbol,
	output logic [lcs_pkg::LEN_W-1:0]   lcs_length,
	output logic                        is_empty,
	output logic                        overflowed,
	output logic                        last
);

	localparam int CW  = $clog2(MAX_LEN + 1);
	localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int DW  = 2 * IW;
	localparam int SW  = lcs_pkg::SYM_W;

	// Sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ROW   = 4'd1;
	localparam logic [3:0] S_ROWW  = 4'd2;
	localparam logic [3:0] S_CELL  = 4'd3;
	localparam logic [3:0] S_CALC  = 4'd4;
	localparam logic [3:0] S_TB    = 4'd5;
	localparam logic [3:0] S_TBW   = 4'd6;
	localparam logic [3:0] S_EMPTY = 4'd7;
	localparam logic [3:0] S_EADDR = 4'd8;
	localparam logic [3:0] S_ELOAD = 4'd9;

	logic [3:0]    state_q;
	logic [CW-1:0] first_count_q, second_count_q;
	logic          drop_q;
	logic [CW-1:0] n1_q, n2_q;
	logic [IW-1:0] ri_q, cj_q;
	logic [CW-1:0] left_q, diag_q;
	logic [SW-1:0] a_sym_q;
	logic [CW-1:0] ti_q, tj_q, k_q;
	logic [IW-1:0] ptr_q;

	logic          res_valid_q;
	logic [SW-1:0] res_symbol_q;
	logic [CW-1:0] res_length_q;
	logic          res_empty_q, res_over_q, res_last_q;

	logic          req_acc;
	logic          a_we, b_we, row_we, dir_we, rev_we;
	logic [IW-1:0] a_rd_addr;
	logic [SW-1:0] a_rd, b_rd, rev_rd;
	logic [CW-1:0] row_rd;
	logic [lcs_pkg::DIR_W-1:0] dir_rd, cell_dir;
	logic [CW-1:0] up, score;
	logic [CW-1:0] n1m1, n2m1, tim1, tjm1, km1;
	logic          out_free, out_load, row_end, col_end, tb_done;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;

	assign n1m1 = n1_q - CW'(1);
	assign n2m1 = n2_q - CW'(1);
	assign tim1 = ti_q - CW'(1);
	assign tjm1 = tj_q - CW'(1);
	assign km1  = k_q - CW'(1);

	assign row_end = (ri_q == n1m1[IW-1:0]);
	assign col_end = (cj_q == n2m1[IW-1:0]);
	assign tb_done = (ti_q == '0) || (tj_q == '0);

	// Store writes
	assign a_we   = req_acc && (req_type == lcs_pkg::REQ_APPEND_A)
		&& (first_count_q < CW'(MAX_LEN));
	assign b_we   = req_acc && (req_type == lcs_pkg::REQ_APPEND_B)
		&& (second_count_q < CW'(MAX_LEN));
	assign row_we = (state_q == S_CALC);
	assign dir_we = (state_q == S_CALC);
	assign rev_we = (state_q == S_TBW) && (dir_rd == lcs_pkg::DIR_DIAG);

	assign a_rd_addr = (state_q == S_TB) ? tim1[IW-1:0] : ri_q;

	lcs_ram #(.WIDTH(SW), .DEPTH(MAX_LEN), .AW(IW)) u_first (
		.clk(clk), .we(a_we), .wr_addr(first_count_q[IW-1:0]), .wr_data(symbol),
		.rd_addr(a_rd_addr), .rd_data(a_rd)
	);

	lcs_ram #(.WIDTH(SW), .DEPTH(MAX_LEN), .AW(IW)) u_second (
		.clk(clk), .we(b_we), .wr_addr(second_count_q[IW-1:0]), .wr_data(symbol),
		.rd_addr(cj_q), .rd_data(b_rd)
	);

	// One score row, overwritten in place: read prev[j], write cur[j]
	lcs_ram #(.WIDTH(CW), .DEPTH(MAX_LEN), .AW(IW)) u_row (
		.clk(clk), .we(row_we), .wr_addr(cj_q), .wr_data(score),
		.rd_addr(cj_q), .rd_data(row_rd)
	);

	lcs_ram #(.WIDTH(lcs_pkg::DIR_W), .DEPTH(2 ** DW), .AW(DW)) u_dir (
		.clk(clk), .we(dir_we), .wr_addr({ri_q, cj_q}), .wr_data(cell_dir),
		.rd_addr({tim1[IW-1:0], tjm1[IW-1:0]}), .rd_data(dir_rd)
	);

	lcs_ram #(.WIDTH(SW), .DEPTH(MAX_LEN), .AW(IW)) u_rev (
		.clk(clk), .we(rev_we), .wr_addr(k_q[IW-1:0]), .wr_data(a_rd),
		.rd_addr(ptr_q), .rd_data(rev_rd)
	);

	// Cell update: the shared compare/add unit
	always_comb begin
		up = (ri_q == '0) ? '0 : row_rd;
		if (a_sym_q == b_rd) begin
			score    = diag_q + CW'(1);
			cell_dir = lcs_pkg::DIR_DIAG;
		end else if (up >= left_q) begin
			score    = up;
			cell_dir = lcs_pkg::DIR_UP;
		end else begin
			score    = left_q;
			cell_dir = lcs_pkg::DIR_LEFT;
		end
	end

	assign out_free = !res_valid_q || !res_stall;
	assign out_load = out_free && ((state_q == S_EMPTY) || (state_q == S_ELOAD));

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			first_count_q  <= '0;
			second_count_q <= '0;
			drop_q         <= 1'b0;
			n1_q           <= '0;
			n2_q           <= '0;
			ri_q           <= '0;
			cj_q           <= '0;
			left_q         <= '0;
			diag_q         <= '0;
			a_sym_q        <= '0;
			ti_q           <= '0;
			tj_q           <= '0;
			k_q            <= '0;
			ptr_q          <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						case (req_type)
							lcs_pkg::REQ_APPEND_A: begin
								if (a_we) first_count_q <= first_count_q + CW'(1);
								else      drop_q        <= 1'b1;
							end
							lcs_pkg::REQ_APPEND_B: begin
								if (b_we) second_count_q <= second_count_q + CW'(1);
								else      drop_q         <= 1'b1;
							end
							lcs_pkg::REQ_COMPUTE: begin
								n1_q           <= first_count_q;
								n2_q           <= second_count_q;
								first_count_q  <= '0;
								second_count_q <= '0;
								ri_q           <= '0;
								k_q            <= '0;
								if ((first_count_q == '0) || (second_count_q == '0)) begin
									state_q <= S_EMPTY;
								end else begin
									state_q <= S_ROW;
								end
							end
							default: ;
						endcase
					end
				end
				S_ROW: begin
					state_q <= S_ROWW;
				end
				S_ROWW: begin
					a_sym_q <= a_rd;
					cj_q    <= '0;
					left_q  <= '0;
					diag_q  <= '0;
					state_q <= S_CELL;
				end
				S_CELL: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					left_q <= score;
					diag_q <= up;
					if (!col_end) begin
						cj_q    <= cj_q + IW'(1);
						state_q <= S_CELL;
					end else if (!row_end) begin
						ri_q    <= ri_q + IW'(1);
						state_q <= S_ROW;
					end else begin
						ti_q    <= n1_q;
						tj_q    <= n2_q;
						state_q <= S_TB;
					end
				end
				S_TB: begin
					if (!tb_done) begin
						state_q <= S_TBW;
					end else if (k_q == '0) begin
						state_q <= S_EMPTY;
					end else begin
						ptr_q   <= km1[IW-1:0];
						state_q <= S_EADDR;
					end
				end
				S_TBW: begin
					case (dir_rd)
						lcs_pkg::DIR_DIAG: begin
							k_q  <= k_q + CW'(1);
							ti_q <= tim1;
							tj_q <= tjm1;
						end
						lcs_pkg::DIR_UP: ti_q <= tim1;
						default:         tj_q <= tjm1;
					endcase
					state_q <= S_TB;
				end
				S_EMPTY: begin
					if (out_free) state_q <= S_IDLE;
				end
				S_EADDR: begin
					state_q <= S_ELOAD;
				end
				S_ELOAD: begin
					if (out_free) begin
						if (ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_q - IW'(1);
							state_q <= S_EADDR;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_over_q <= drop_q;
			if (state_q == S_EMPTY) begin
				res_symbol_q <= '0;
				res_length_q <= '0;
				res_empty_q  <= 1'b1;
				res_last_q   <= 1'b1;
			end else begin
				res_symbol_q <= rev_rd;
				res_length_q <= k_q;
				res_empty_q  <= 1'b0;
				res_last_q   <= (ptr_q == '0);
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign lcs_symbol = res_symbol_q;
	assign lcs_length = lcs_pkg::LEN_W'(res_length_q);
	assign is_empty   = res_empty_q;
	assign overflowed = res_over_q;
	assign last       = res_last_q;

	// An empty result is always the final one and carries zero length
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_empty |-> last && (lcs_length == '0))
		else $error("empty result without last or with nonzero length");

	// The result register is never overwritten while it is held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_load && res_valid && res_stall))
		else $error("result register loaded while stalled");

	// Traceback stays inside the filled table and the reverse buffer
	a_tb_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TB || state_q == S_TBW) |-> (ti_q <= n1_q) && (tj_q <= n2_q))
		else $error("traceback left the table");

	a_rev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rev_we |-> (k_q < CW'(MAX_LEN)))
		else $error("reverse buffer written beyond its depth");

endmodule
